>>> src/scnl_pkg.sv
package scnl_pkg;

    localparam int unsigned TimeW     = 32;
    localparam int unsigned CountW    = 11;
    localparam int unsigned SumW      = 64;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned MaxLineages = 1024;
    localparam int unsigned DivShift  = 48;
    localparam int unsigned DivSteps  = 64 + DivShift;
    localparam int unsigned DivCntW   = $clog2(DivSteps);

    localparam logic [31:0] Ln2Q32 = 32'd2977044472;
    localparam logic [63:0] SatMax = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SatMin = 64'h8000_0000_0000_0000;

    localparam logic [CfgIdxW-1:0] RegPopSize    = 2'd0;
    localparam logic [CfgIdxW-1:0] RegSizeRatio  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegChangeTime = 2'd2;

    typedef struct packed {
        logic        start;
        logic [63:0] opnd;
    } t_unit_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_unit_rsp;

endpackage

>>> src/scnl_div.sv
module scnl_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scnl_pkg::t_unit_req i_req,
    input  logic [63:0]         i_den,
    output scnl_pkg::t_unit_rsp o_rsp
);

    logic                          r_busy, n_busy;
    logic [scnl_pkg::DivCntW-1:0]  r_cnt, n_cnt;
    logic [63:0]                   r_num, n_num;
    logic [63:0]                   r_den, n_den;
    logic [63:0]                   r_rem, n_rem;
    logic [63:0]                   r_quo, n_quo;
    logic                          r_sat, n_sat;
    logic                          r_done, n_done;
    logic [63:0]                   w_shift;
    logic                          w_bit;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_sat  = r_sat;
        n_done = 1'b0;
        w_bit  = (r_cnt < scnl_pkg::DivCntW'(64)) ? r_num[63] : 1'b0;
        w_shift = {r_rem[62:0], w_bit};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_req.opnd;
            n_den  = i_den;
            n_rem  = '0;
            n_quo  = '0;
            n_sat  = 1'b0;
        end else if (r_busy) begin
            n_num = {r_num[62:0], 1'b0};
            if (r_quo[63:62] != 2'b00) begin
                n_sat = 1'b1;
            end
            if (r_rem[63] || (w_shift >= r_den)) begin
                n_rem = w_shift - r_den;
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == scnl_pkg::DivCntW'(scnl_pkg::DivSteps - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_sat <= n_sat;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_sat ? scnl_pkg::SatMax : {1'b0, r_quo[62:0]};

endmodule

>>> src/scnl_log2.sv
module scnl_log2 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scnl_pkg::t_unit_req i_req,
    output scnl_pkg::t_unit_rsp o_rsp
);

    localparam logic [1:0] PhIdle = 2'd0;
    localparam logic [1:0] PhNorm = 2'd1;
    localparam logic [1:0] PhSq   = 2'd2;

    logic [1:0]  r_ph, n_ph;
    logic [63:0] r_x, n_x;
    logic [5:0]  r_shamt, n_shamt;
    logic [31:0] r_z, n_z;
    logic [31:0] r_frac, n_frac;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [63:0] w_sq;
    logic [32:0] w_t;

    assign w_sq = {32'd0, r_z} * {32'd0, r_z};
    assign w_t  = w_sq[63:31];

    always_comb begin
        n_ph    = r_ph;
        n_x     = r_x;
        n_shamt = r_shamt;
        n_z     = r_z;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_ph)
            PhIdle: begin
                if (i_req.start) begin
                    n_ph    = PhNorm;
                    n_x     = i_req.opnd;
                    n_shamt = '0;
                end
            end
            PhNorm: begin
                priority if (r_x[63:48] == 16'd0) begin
                    n_x = {r_x[47:0], 16'd0};
                    n_shamt = r_shamt + 6'd16;
                end else if (r_x[63:56] == 8'd0) begin
                    n_x = {r_x[55:0], 8'd0};
                    n_shamt = r_shamt + 6'd8;
                end else if (r_x[63:60] == 4'd0) begin
                    n_x = {r_x[59:0], 4'd0};
                    n_shamt = r_shamt + 6'd4;
                end else if (r_x[63:62] == 2'd0) begin
                    n_x = {r_x[61:0], 2'd0};
                    n_shamt = r_shamt + 6'd2;
                end else if (!r_x[63]) begin
                    n_x = {r_x[62:0], 1'b0};
                    n_shamt = r_shamt + 6'd1;
                end else begin
                    n_z    = r_x[63:32];
                    n_frac = '0;
                    n_cnt  = '0;
                    n_ph   = PhSq;
                end
            end
            PhSq: begin
                n_frac = {r_frac[30:0], w_t[32]};
                n_z    = w_t[32] ? w_t[32:1] : w_t[31:0];
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    n_ph   = PhIdle;
                    n_done = 1'b1;
                end
            end
            default: n_ph = PhIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PhIdle;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end
        r_x     <= n_x;
        r_shamt <= n_shamt;
        r_z     <= n_z;
        r_frac  <= n_frac;
        r_cnt   <= n_cnt;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = {26'd0, 6'd63 - r_shamt, r_frac};

endmodule

>>> src/step_coalescent_neg_loglik.sv
// Step-size coalescent negative log-likelihood, one genealogy interval per beat.
// Input beats on s_axis carry start time, end time and the two lineage counts
// in tdata; tlast marks the last interval of a tree. Each input beat yields one
// output beat on m_axis: tdata is the negated running log-likelihood in signed
// Q32.32, tuser is the sticky invalid flag and tlast copies the input tlast.
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must write them only while idle, as the block itself does not enforce this.
// The output beat for an interval that spans the change time takes longer than
// for a plain one, as it needs a second division. The bit-serial divider sets
// the pace, and a coalescent interval adds two logarithms on the iterative
// squaring unit and the scaling by ln 2.
// s_axis_tready is high only while the sequencer is idle. A finished result is
// held in the output register; the block accepts the next item while it waits
// but stalls before writing a second result until the first beat is taken.
// Synchronous reset clears the running sum, the error flag, the registers to
// their defaults and any pending output beat.
module step_coalescent_neg_loglik (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // interval_start[31:0], interval_end[63:32], lineages_start[74:64],
    // lineages_end[85:75], zero pad[87:86]
    input  logic [87:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // neg_loglik[63:0]
    output logic [63:0] m_axis_tdata,
    // invalid[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam logic [4:0] StIdle = 5'd0;
    localparam logic [4:0] StCh   = 5'd1;
    localparam logic [4:0] StSp   = 5'd2;
    localparam logic [4:0] StSel  = 5'd3;
    localparam logic [4:0] StM1   = 5'd4;
    localparam logic [4:0] StD1   = 5'd5;
    localparam logic [4:0] StD1W  = 5'd6;
    localparam logic [4:0] StM2   = 5'd7;
    localparam logic [4:0] StD2   = 5'd8;
    localparam logic [4:0] StD2W  = 5'd9;
    localparam logic [4:0] StLg   = 5'd10;
    localparam logic [4:0] StL1W  = 5'd11;
    localparam logic [4:0] StL2W  = 5'd12;
    localparam logic [4:0] StMl   = 5'd13;
    localparam logic [4:0] StMh   = 5'd14;
    localparam logic [4:0] StLn   = 5'd15;
    localparam logic [4:0] StAcc  = 5'd16;

    logic [4:0]  r_st, n_st;
    logic [31:0] r_pop, r_ratio, r_chg;
    logic [31:0] r_t0, r_t1;
    logic [10:0] r_ls, r_le;
    logic        r_last;
    logic [10:0] r_a;
    logic [31:0] r_ch;
    logic [63:0] r_spre, r_slog, r_den1, r_den2;
    logic [31:0] r_dt1, r_dt2;
    logic        r_split;
    logic [63:0] r_integ, r_l1, r_mag, r_lo;
    logic        r_neg;
    logic [63:0] r_sum;
    logic        r_err;
    logic [63:0] r_prod;
    logic [31:0] w_ma, w_mb;
    logic        r_ovalid;
    logic [63:0] r_odata;
    logic        r_ouser, r_olast;

    scnl_pkg::t_unit_req w_dreq, w_lreq;
    scnl_pkg::t_unit_rsp w_drsp, w_lrsp;
    logic [63:0] w_dden;

    logic [31:0] w_t0, w_t1in, w_t1;
    logic [10:0] w_ls, w_a;
    logic [63:0] w_spost, w_l2, w_p, w_lnval, w_acc, w_isum;
    logic        w_coal, w_ofree;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? scnl_pkg::SatMin : scnl_pkg::SatMax;
        end
        return s[63:0];
    endfunction

    assign w_t0   = s_axis_tdata[31:0];
    assign w_t1in = s_axis_tdata[63:32];
    assign w_t1   = (w_t1in < w_t0) ? w_t0 : w_t1in;
    assign w_ls   = s_axis_tdata[74:64];
    assign w_a    = (w_ls > 11'(scnl_pkg::MaxLineages)) ? 11'(scnl_pkg::MaxLineages) : w_ls;

    assign w_spost = (r_prod == 64'd0) ? 64'd1 : r_prod;
    assign w_coal  = (r_ls >= 11'd1) && (r_le == r_ls - 11'd1);
    assign w_l2    = r_l1 - w_lrsp.result + {32'd32, 32'd0};
    assign w_p     = r_prod + {32'd0, r_lo[63:32]};
    assign w_lnval = r_neg ? (64'd0 - w_p) : w_p;
    assign w_acc   = sat_add(r_sum, 64'd0 - r_integ);
    assign w_isum  = (r_integ + w_drsp.result);
    assign w_ofree = !r_ovalid || m_axis_tready;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_st)
            StCh: begin
                if (r_a >= 11'd2) begin
                    w_ma = {21'd0, r_a};
                    w_mb = {21'd0, r_a - 11'd1};
                end
            end
            StSp: begin
                w_ma = r_pop;
                w_mb = r_ratio;
            end
            StM1: begin
                w_ma = r_ch;
                w_mb = r_dt1;
            end
            StM2: begin
                w_ma = r_ch;
                w_mb = r_dt2;
            end
            StMl: begin
                w_ma = r_mag[31:0];
                w_mb = scnl_pkg::Ln2Q32;
            end
            StMh: begin
                w_ma = r_mag[63:32];
                w_mb = scnl_pkg::Ln2Q32;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        w_dreq.start = (r_st == StD1) || (r_st == StD2);
        w_dreq.opnd  = r_prod;
        w_dden       = (r_st == StD2) ? r_den2 : r_den1;
        w_lreq.start = ((r_st == StLg) && w_coal && (r_ls >= 11'd2))
                       || ((r_st == StL1W) && w_lrsp.done);
        w_lreq.opnd  = (r_st == StLg) ? {32'd0, r_ch} : r_slog;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            StIdle: if (s_axis_tvalid) begin
                n_st = StCh;
            end
            StCh:  n_st = StSp;
            StSp:  n_st = StSel;
            StSel: n_st = StM1;
            StM1:  n_st = StD1;
            StD1:  n_st = StD1W;
            StD1W: if (w_drsp.done) begin
                n_st = r_split ? StM2 : StLg;
            end
            StM2:  n_st = StD2;
            StD2:  n_st = StD2W;
            StD2W: if (w_drsp.done) begin
                n_st = StLg;
            end
            StLg:  n_st = (w_coal && (r_ls >= 11'd2)) ? StL1W : StAcc;
            StL1W: if (w_lrsp.done) begin
                n_st = StL2W;
            end
            StL2W: if (w_lrsp.done) begin
                n_st = StMl;
            end
            StMl:  n_st = StMh;
            StMh:  n_st = StLn;
            StLn:  n_st = StAcc;
            StAcc: if (w_ofree) begin
                n_st = StIdle;
            end
            default: n_st = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, w_ma} * {32'd0, w_mb};
        if (!i_rst_n) begin
            r_st     <= StIdle;
            r_pop    <= 32'd65536;
            r_ratio  <= 32'd65536;
            r_chg    <= 32'd0;
            r_sum    <= '0;
            r_err    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    scnl_pkg::RegPopSize:    r_pop   <= i_cfg_data;
                    scnl_pkg::RegSizeRatio:  r_ratio <= i_cfg_data;
                    scnl_pkg::RegChangeTime: r_chg   <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_st == StLg) && w_coal && (r_ls < 11'd2)) begin
                r_err <= 1'b1;
            end
            if (r_st == StLn) begin
                r_sum <= sat_add(r_sum, w_lnval);
            end
            if ((r_st == StAcc) && w_ofree) begin
                r_ovalid <= 1'b1;
                r_sum    <= r_last ? 64'd0 : w_acc;
                if (r_last) begin
                    r_err <= 1'b0;
                end
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        unique case (r_st)
            StIdle: begin
                r_t0   <= w_t0;
                r_t1   <= w_t1;
                r_ls   <= w_ls;
                r_le   <= s_axis_tdata[85:75];
                r_last <= s_axis_tlast;
                r_a    <= w_a;
            end
            StSp: begin
                r_ch   <= r_prod[32:1];
                r_spre <= (r_pop == 32'd0) ? 64'd1 : {16'd0, r_pop, 16'd0};
            end
            StSel: begin
                if (r_t1 < r_chg) begin
                    r_dt1   <= r_t1 - r_t0;
                    r_den1  <= r_spre;
                    r_slog  <= r_spre;
                    r_split <= 1'b0;
                end else if (r_t0 >= r_chg) begin
                    r_dt1   <= r_t1 - r_t0;
                    r_den1  <= w_spost;
                    r_slog  <= w_spost;
                    r_split <= 1'b0;
                end else begin
                    r_dt1   <= r_chg - r_t0;
                    r_den1  <= r_spre;
                    r_dt2   <= r_t1 - r_chg;
                    r_den2  <= w_spost;
                    r_slog  <= w_spost;
                    r_split <= 1'b1;
                end
            end
            StD1W: if (w_drsp.done) begin
                r_integ <= w_drsp.result;
            end
            StD2W: if (w_drsp.done) begin
                r_integ <= w_isum[63] ? scnl_pkg::SatMax : w_isum;
            end
            StL1W: if (w_lrsp.done) begin
                r_l1 <= w_lrsp.result;
            end
            StL2W: if (w_lrsp.done) begin
                r_neg <= w_l2[63];
                r_mag <= w_l2[63] ? (64'd0 - w_l2) : w_l2;
            end
            StMh: r_lo <= r_prod;
            StAcc: if (w_ofree) begin
                r_odata <= (w_acc == scnl_pkg::SatMin) ? scnl_pkg::SatMax
                                                       : (64'd0 - w_acc);
                r_ouser <= r_err;
                r_olast <= r_last;
            end
            default: ;
        endcase
    end

    scnl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .i_den   (w_dden),
        .o_rsp   (w_drsp)
    );

    scnl_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_lreq),
        .o_rsp   (w_lrsp)
    );

    assign s_axis_tready = (r_st == StIdle);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule

>>> src/scnl_checker.sv
module scnl_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output beat pending after reset.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input ready right after an accepted beat.");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Stalled output beat changed.");

    a_out_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("Output beat appeared while the sequencer was busy.");

endmodule

bind step_coalescent_neg_loglik scnl_assert u_scnl_assert (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
